// ----- src/a51_pkg.sv -----
`timescale 1ns / 1ps
// Package for the A5/1 keystream cipher unit: widths, register indexes,
// controller state codes, command/status structs and LFSR step functions.
// No dependencies.
package a51_pkg;

  localparam int unsigned R1_W      = 19;
  localparam int unsigned R2_W      = 22;
  localparam int unsigned R3_W      = 23;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned FRAME_W   = 22;
  localparam int unsigned DISC_W    = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SEED_W    = KEY_W + FRAME_W;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned IDX_W     = 2;

  localparam logic [DISC_W-1:0] DISC_RESET = 8'd100;
  localparam logic [CNT_W-1:0]  LOAD_LAST  = 8'(SEED_W - 1);
  localparam logic [CNT_W-1:0]  BYTE_LAST  = 8'(BYTE_W - 1);

  localparam int unsigned R1_CLK = 8;
  localparam int unsigned R2_CLK = 10;
  localparam int unsigned R3_CLK = 10;

  typedef enum logic [IDX_W-1:0] {
    REG_KEY     = 2'd0,
    REG_FRAME   = 2'd1,
    REG_DISCARD = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    MODE_INIT    = 1'b0,
    MODE_ENCRYPT = 1'b1
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_LOAD    = 5'b00010,
    ST_DISCARD = 5'b00100,
    ST_KSTREAM = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_t;

  typedef struct packed {
    logic start_init;
    logic step_load;
    logic start_discard;
    logic step_major;
    logic start_enc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic disc_zero;
    logic out_free;
  } status_t;

  function automatic logic [R1_W-1:0] clk_one(input logic [R1_W-1:0] r, input logic inj);
    logic fb;
    fb = r[18] ^ r[17] ^ r[16] ^ r[13] ^ inj;
    return {r[R1_W-2:0], fb};
  endfunction

  function automatic logic [R2_W-1:0] clk_two(input logic [R2_W-1:0] r, input logic inj);
    logic fb;
    fb = r[21] ^ r[20] ^ inj;
    return {r[R2_W-2:0], fb};
  endfunction

  function automatic logic [R3_W-1:0] clk_three(input logic [R3_W-1:0] r, input logic inj);
    logic fb;
    fb = r[22] ^ r[21] ^ r[20] ^ r[7] ^ inj;
    return {r[R3_W-2:0], fb};
  endfunction

endpackage

// ----- src/a51_regs.sv -----
`timescale 1ns / 1ps
// APB-style configuration registers: session key, frame number, discard count.
// Depends on a51_pkg.
module a51_regs
  import a51_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  output logic [KEY_W-1:0]    key,
  output logic [FRAME_W-1:0]  frame,
  output logic [DISC_W-1:0]   discard
);

  logic [KEY_W-1:0]   key_r,   key_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [DISC_W-1:0]  disc_r,  disc_nxt;
  reg_idx_t           idx;
  logic               wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    key_nxt   = key_r;
    frame_nxt = frame_r;
    disc_nxt  = disc_r;
    prdata    = '0;
    unique case (idx)
      REG_KEY: begin
        prdata = key_r;
        if (wr_en) key_nxt = pwdata;
      end
      REG_FRAME: begin
        prdata = {{(DATA_W-FRAME_W){1'b0}}, frame_r};
        if (wr_en) frame_nxt = pwdata[FRAME_W-1:0];
      end
      REG_DISCARD: begin
        prdata = {{(DATA_W-DISC_W){1'b0}}, disc_r};
        if (wr_en) disc_nxt = pwdata[DISC_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      frame_r <= '0;
      disc_r  <= DISC_RESET;
    end else begin
      key_r   <= key_nxt;
      frame_r <= frame_nxt;
      disc_r  <= disc_nxt;
    end
  end

  assign key     = key_r;
  assign frame   = frame_r;
  assign discard = disc_r;

endmodule

// ----- src/a51_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: three LFSRs, seed shifter, step counter, keystream collector and
// output register. Depends on a51_pkg.
module a51_datapath
  import a51_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [KEY_W-1:0]   key,
  input  logic [FRAME_W-1:0] frame,
  input  logic [DISC_W-1:0]  discard,
  input  logic [BYTE_W-1:0]  data_in,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [BYTE_W-1:0]  out_byte
);

  logic [R1_W-1:0]   r1_r,   r1_nxt;
  logic [R2_W-1:0]   r2_r,   r2_nxt;
  logic [R3_W-1:0]   r3_r,   r3_nxt;
  logic [SEED_W-1:0] seed_r, seed_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [BYTE_W-1:0] ks_r,   ks_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic              a, b, c, maj;

  assign a   = r1_r[R1_CLK];
  assign b   = r2_r[R2_CLK];
  assign c   = r3_r[R3_CLK];
  assign maj = (a & b) | (a & c) | (b & c);

  always_comb begin
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    r3_nxt    = r3_r;
    seed_nxt  = seed_r;
    cnt_nxt   = cnt_r;
    ks_nxt    = ks_r;
    data_nxt  = data_r;
    obyte_nxt = obyte_r;
    ovalid_nxt = ovalid_r & out_stall;

    if (cmd.start_init) begin
      r1_nxt   = '0;
      r2_nxt   = '0;
      r3_nxt   = '0;
      seed_nxt = {frame, key};
      cnt_nxt  = LOAD_LAST;
    end
    if (cmd.step_load) begin
      r1_nxt   = clk_one(r1_r, seed_r[0]);
      r2_nxt   = clk_two(r2_r, seed_r[0]);
      r3_nxt   = clk_three(r3_r, seed_r[0]);
      seed_nxt = {1'b0, seed_r[SEED_W-1:1]};
      cnt_nxt  = cnt_r - 1'b1;
    end
    if (cmd.step_major) begin
      if (a == maj) r1_nxt = clk_one(r1_r, 1'b0);
      if (b == maj) r2_nxt = clk_two(r2_r, 1'b0);
      if (c == maj) r3_nxt = clk_three(r3_r, 1'b0);
      ks_nxt  = {r1_nxt[R1_W-1] ^ r2_nxt[R2_W-1] ^ r3_nxt[R3_W-1], ks_r[BYTE_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
    end
    if (cmd.start_discard) cnt_nxt = discard - 1'b1;
    if (cmd.start_enc) begin
      data_nxt = data_in;
      cnt_nxt  = BYTE_LAST;
    end
    if (cmd.emit) begin
      obyte_nxt  = data_r ^ ks_r;
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_r     <= '0;
      r2_r     <= '0;
      r3_r     <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      r1_r     <= r1_nxt;
      r2_r     <= r2_nxt;
      r3_r     <= r3_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_r  <= seed_nxt;
    ks_r    <= ks_nxt;
    data_r  <= data_nxt;
    obyte_r <= obyte_nxt;
  end

  assign status.cnt_zero  = (cnt_r == '0);
  assign status.disc_zero = (discard == '0);
  assign status.out_free  = ~ovalid_r | ~out_stall;
  assign out_valid        = ovalid_r;
  assign out_byte         = obyte_r;

endmodule

// ----- src/a51_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences loading, discard clocking and byte
// encryption through commands to the datapath. Depends on a51_pkg.
module a51_ctrl
  import a51_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_mode,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode_t'(in_mode) == MODE_INIT) begin
            cmd.start_init = 1'b1;
            state_nxt      = ST_LOAD;
          end else begin
            cmd.start_enc = 1'b1;
            state_nxt     = ST_KSTREAM;
          end
        end
      end
      ST_LOAD: begin
        cmd.step_load = 1'b1;
        if (status.cnt_zero) begin
          if (status.disc_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.start_discard = 1'b1;
            state_nxt         = ST_DISCARD;
          end
        end
      end
      ST_DISCARD: begin
        cmd.step_major = 1'b1;
        if (status.cnt_zero) state_nxt = ST_IDLE;
      end
      ST_KSTREAM: begin
        cmd.step_major = 1'b1;
        if (status.cnt_zero) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ----- src/a51_keystream_cipher_unit.sv -----
`timescale 1ns / 1ps
// Top level of the A5/1 keystream cipher unit: configuration registers,
// controller and datapath. Depends on a51_pkg, a51_regs, a51_ctrl, a51_datapath.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_mode, in_data_byte
//   out_     output     out_valid / out_stall  out_cipher_byte
//   config   APB slave  psel, penable, pready  paddr, pwdata, prdata (64 bit)
//
// Encrypt transaction: acceptance, majority clocks of the shared LFSR datapath, one step
// to load the output register. Initialize transaction: acceptance, one LFSR clock per
// key and frame bit, then discard_clocks majority clocks; one LFSR clock per cycle.
// Reset (rst_n low, synchronous) clears the LFSRs, controller and key/frame, and sets
// discard_clocks to 100. A stalled result holds in the output register; the
// next transaction is taken meanwhile and waits only at its own emit step.
module a51_keystream_cipher_unit
  import a51_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [BYTE_W-1:0]  in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_cipher_byte,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [KEY_W-1:0]   key;
  logic [FRAME_W-1:0] frame;
  logic [DISC_W-1:0]  discard;
  cmd_t               cmd;
  status_t            status;

  a51_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key),
    .frame   (frame),
    .discard (discard)
  );

  a51_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  a51_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .key       (key),
    .frame     (frame),
    .discard   (discard),
    .data_in   (in_data_byte),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_cipher_byte)
  );

endmodule

// ----- dv/a51_keystream_cipher_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for a51_keystream_cipher_unit: directed and random
// initialize/encrypt traffic over the valid/stall channels, APB register writes
// and a transaction-level A5/1 keystream predictor. Depends on a51_pkg and the RTL.
module a51_keystream_cipher_unit_test;
  import a51_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned INIT_SETTLE = 1 + SEED_W + 255 + 16;
  localparam int unsigned END_SETTLE  = 400;

  localparam logic [R1_W-1:0] A_TAPS = 19'h72000;
  localparam logic [R2_W-1:0] B_TAPS = 22'h300000;
  localparam logic [R3_W-1:0] C_TAPS = 23'h700080;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_mode;
  logic [BYTE_W-1:0] in_data_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_cipher_byte;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [R1_W-1:0]    lfsr_a = '0;
  logic [R2_W-1:0]    lfsr_b = '0;
  logic [R3_W-1:0]    lfsr_c = '0;
  logic [KEY_W-1:0]   cur_key = '0;
  logic [FRAME_W-1:0] cur_frame = '0;
  logic [DISC_W-1:0]  cur_discard = DISC_RESET;

  logic [BYTE_W-1:0] pending_cipher_bytes[$];
  int                mismatches = 0;
  int                sent_count = 0;
  bit                idle_on = 1'b1;

  a51_keystream_cipher_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_byte (out_cipher_byte),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  function automatic logic [R1_W-1:0] next_a(input logic [R1_W-1:0] r, input logic inj);
    return {r[R1_W-2:0], (^(r & A_TAPS)) ^ inj};
  endfunction

  function automatic logic [R2_W-1:0] next_b(input logic [R2_W-1:0] r, input logic inj);
    return {r[R2_W-2:0], (^(r & B_TAPS)) ^ inj};
  endfunction

  function automatic logic [R3_W-1:0] next_c(input logic [R3_W-1:0] r, input logic inj);
    return {r[R3_W-2:0], (^(r & C_TAPS)) ^ inj};
  endfunction

  task automatic clock_majority_vote;
    logic a, b, c, maj;
    a   = lfsr_a[R1_CLK];
    b   = lfsr_b[R2_CLK];
    c   = lfsr_c[R3_CLK];
    maj = (a & b) | (a & c) | (b & c);
    if (a == maj) lfsr_a = next_a(lfsr_a, 1'b0);
    if (b == maj) lfsr_b = next_b(lfsr_b, 1'b0);
    if (c == maj) lfsr_c = next_c(lfsr_c, 1'b0);
  endtask

  task automatic clock_seed_bit(input logic inj);
    lfsr_a = next_a(lfsr_a, inj);
    lfsr_b = next_b(lfsr_b, inj);
    lfsr_c = next_c(lfsr_c, inj);
  endtask

  task automatic advance_keystream(input mode_t mode, input logic [BYTE_W-1:0] data_val);
    logic [BYTE_W-1:0] ks;
    if (mode == MODE_INIT) begin
      lfsr_a = '0;
      lfsr_b = '0;
      lfsr_c = '0;
      for (int i = 0; i < KEY_W; i++) clock_seed_bit(cur_key[i]);
      for (int i = 0; i < FRAME_W; i++) clock_seed_bit(cur_frame[i]);
      for (int i = 0; i < int'(cur_discard); i++) clock_majority_vote();
    end else begin
      ks = '0;
      for (int i = 0; i < BYTE_W; i++) begin
        clock_majority_vote();
        ks[i] = lfsr_a[R1_W-1] ^ lfsr_b[R2_W-1] ^ lfsr_c[R3_W-1];
      end
      pending_cipher_bytes.push_back(data_val ^ ks);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Entered and left at a falling edge; in_valid is left high for the caller.
  task automatic send_item(input mode_t mode, input logic [BYTE_W-1:0] data_val);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= data_val;
    do @(posedge clk); while (!(in_valid && !in_stall));
    advance_keystream(mode, data_val);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_KEY:     cur_key = value;
      REG_FRAME:   cur_frame = value[FRAME_W-1:0];
      REG_DISCARD: cur_discard = value[DISC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic pause_for_results;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_cipher_bytes.size() != 0);
  endtask

  // Drain results and let any initialize transaction run out.
  task automatic settle_block;
    pause_for_results();
    repeat (INIT_SETTLE) @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] rand_data;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [KEY_W-1:0] rand_key;
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_passthrough_after_reset;
    send_item(MODE_ENCRYPT, 8'h00);
    send_item(MODE_ENCRYPT, 8'hFF);
    send_item(MODE_ENCRYPT, 8'hA5);
    send_item(MODE_ENCRYPT, 8'h5A);
  endtask

  task automatic test_standard_session;
    settle_block();
    write_register(REG_KEY, 64'h911A2B3C4D5E6F0F);
    write_register(REG_FRAME, 64'h134);
    send_item(MODE_INIT, 8'hFF);
    send_item(MODE_ENCRYPT, 8'h00);
    send_item(MODE_ENCRYPT, 8'hFF);
    send_item(MODE_ENCRYPT, 8'h0F);
    send_item(MODE_ENCRYPT, 8'hF0);
  endtask

  task automatic test_register_extremes;
    settle_block();
    write_register(REG_KEY, '1);
    write_register(REG_FRAME, 64'h3FFFFF);
    write_register(REG_DISCARD, 64'd0);
    send_item(MODE_INIT, 8'h00);
    send_item(MODE_ENCRYPT, 8'h00);
    send_item(MODE_ENCRYPT, 8'hFF);
    settle_block();
    write_register(REG_KEY, '0);
    write_register(REG_FRAME, '0);
    write_register(REG_DISCARD, 64'd255);
    send_item(MODE_INIT, 8'hFF);
    send_item(MODE_ENCRYPT, 8'h55);
    send_item(MODE_ENCRYPT, 8'hAA);
    settle_block();
    write_register(REG_KEY, rand_key());
    write_register(REG_DISCARD, 64'd20);
    send_item(MODE_INIT, rand_data());
    send_item(MODE_ENCRYPT, rand_data());
    send_item(MODE_ENCRYPT, rand_data());
  endtask

  // Writes after initialize must not disturb the running keystream.
  task automatic test_late_writes;
    settle_block();
    write_register(REG_KEY, rand_key());
    write_register(REG_FRAME, 64'($urandom_range(0, 22'h3FFFFF)));
    write_register(REG_NONE, rand_key());
    send_item(MODE_ENCRYPT, rand_data());
    send_item(MODE_ENCRYPT, rand_data());
    send_item(MODE_INIT, rand_data());
    send_item(MODE_ENCRYPT, rand_data());
    send_item(MODE_ENCRYPT, rand_data());
  endtask

  task automatic write_random_config;
    int pick;
    if ($urandom_range(0, 3) != 0) write_register(REG_KEY, rand_key());
    if ($urandom_range(0, 2) != 0)
      write_register(REG_FRAME, 64'($urandom_range(0, 22'h3FFFFF)));
    if ($urandom_range(0, 2) != 0) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       write_register(REG_DISCARD, 64'd255);
        1:       write_register(REG_DISCARD, 64'd0);
        2:       write_register(REG_DISCARD, 64'd100);
        3:       write_register(REG_DISCARD, 64'd20);
        default: write_register(REG_DISCARD, 64'($urandom_range(0, 40)));
      endcase
    end
    if ($urandom_range(0, 9) == 0) write_register(REG_NONE, rand_key());
  endtask

  task automatic test_random_sessions;
    int burst;
    while (sent_count < 360) begin
      idle_on = ($urandom_range(0, 3) != 0);
      settle_block();
      write_random_config();
      if ($urandom_range(0, 7) != 0) send_item(MODE_INIT, rand_data());
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        if ($urandom_range(0, 19) == 0) send_item(MODE_INIT, rand_data());
        else send_item(MODE_ENCRYPT, rand_data());
        if ($urandom_range(0, 29) == 0) pause_for_results();
      end
    end
  endtask

  task automatic test_steady_stream;
    idle_on = 1'b0;
    settle_block();
    write_register(REG_KEY, rand_key());
    write_register(REG_FRAME, 64'($urandom_range(0, 22'h3FFFFF)));
    write_register(REG_DISCARD, 64'($urandom_range(0, 40)));
    send_item(MODE_INIT, rand_data());
    repeat (40) send_item(MODE_ENCRYPT, rand_data());
  endtask

  initial begin : result_stall
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cipher_bytes.size() == 0) begin
        report_mismatch($sformatf("cipher_byte %02h with nothing pending", out_cipher_byte));
      end else begin
        if (out_cipher_byte !== pending_cipher_bytes[0])
          report_mismatch($sformatf("cipher_byte got %02h expected %02h",
                                    out_cipher_byte, pending_cipher_bytes[0]));
        void'(pending_cipher_bytes.pop_front());
      end
    end
  end

  initial begin : watchdog
    int stale;
    stale = 0;
    while (stale < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready))
        stale = 0;
      else
        stale++;
    end
    $display("[%0t] timeout: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
    $display("a51_keystream_cipher_unit verification failed");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = MODE_INIT;
    in_data_byte = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_passthrough_after_reset();
    test_standard_session();
    test_register_extremes();
    test_late_writes();
    test_random_sessions();
    test_steady_stream();

    pause_for_results();
    repeat (END_SETTLE) @(negedge clk);
    if (pending_cipher_bytes.size() != 0)
      report_mismatch($sformatf("%0d cipher bytes never delivered", pending_cipher_bytes.size()));

    if (mismatches == 0) begin
      $display("a51_keystream_cipher_unit verification clean");
    end else begin
      $display("a51_keystream_cipher_unit verification failed");
    end
    $finish;
  end

endmodule
